### rtl/dfbs_pkg.sv
// ----------------------------------------------------------------------------
// dfbs_pkg
// Shared types, codes and defaults of the delimited field / byte selector.
// ----------------------------------------------------------------------------
package dfbs_pkg;

  localparam int RANGE_SLOTS_DEF    = 8;
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int RANGE_WIDTH        = 16;
  localparam int PAIR_WIDTH         = 64;
  localparam int PAIR_COUNT         = 4;
  localparam int CFG_INDEX_WIDTH    = 4;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [7:0] DELIM_RESET = 8'h09;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SELECT_MODE   = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIELD_DELIM   = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUPPRESS      = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_COUNT   = 4'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_PAIR_A  = 4'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_PAIR_B  = 4'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_PAIR_C  = 4'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_PAIR_D  = 4'd7;

  typedef enum logic [2:0] {
    KIND_FINAL   = 3'd0,
    KIND_HELD    = 3'd1,
    KIND_KEEP    = 3'd2,
    KIND_DROP    = 3'd3,
    KIND_NEWLINE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

### rtl/delimited_field_byte_selector.sv
// ----------------------------------------------------------------------------
// delimited_field_byte_selector
// Line-oriented byte / field selection over a byte stream, up to eight ranges.
// ----------------------------------------------------------------------------
// An accepted request writes its results to the result queue; out_* show its head.
// Throughput: one request per cycle while each yields at most one result and
//   out_stall is low; a request with two results takes two queue slots, and the
//   four-entry result queue stalls the input when fewer than two slots are free.
// Reset: synchronous; queue empties, counters and registers return to defaults.
module delimited_field_byte_selector #(
  parameter int RANGE_SLOTS    = dfbs_pkg::RANGE_SLOTS_DEF,
  parameter int POSITION_WIDTH = dfbs_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte,
  input  logic                                 line_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_kind,
  output logic [7:0]                           out_byte,
  output logic                                 run_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dfbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dfbs_pkg::PAIR_WIDTH-1:0]      cfg_data
);
  import dfbs_pkg::*;

  localparam int PW  = POSITION_WIDTH;
  localparam int CW  = (PW > RANGE_WIDTH) ? PW : RANGE_WIDTH;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] COUNT_MAX = {PW{1'b1}};

  // configuration
  logic                                   select_mode;
  logic [7:0]                             field_delimiter;
  logic                                   suppress_undelimited;
  logic [3:0]                             range_count;
  logic [PAIR_COUNT-1:0][PAIR_WIDTH-1:0]  range_pair;
  logic [3:0]                             range_active;

  // line state
  logic [PW-1:0] position_count, position_count_next;
  logic [PW-1:0] field_number, field_number_next;
  logic          delimiter_seen, delimiter_seen_next;
  logic          field_written, field_written_next;

  // result queue
  result_t       queue [QUEUE_DEPTH];
  logic [QPW-1:0] rd_ptr, wr_ptr;
  logic [QCW-1:0] fill;

  logic    in_fire, out_fire;
  logic    sel_a, sel_b, is_delim, fw_mid;
  logic    p0, p1;
  result_t slot0, slot1, r0, r1;
  logic [1:0] n_res;
  logic [PW-1:0] pos_inc, fld_inc, sel_pos;

  assign cfg_ready = 1'b1;
  assign range_active = (range_count > 4'(RANGE_SLOTS)) ? 4'(RANGE_SLOTS) : range_count;

  function automatic logic is_sel(input logic [PW-1:0] p);
    logic          hit;
    logic [CW-1:0] pc, fc, lc;
    logic [RANGE_WIDTH-1:0] f, l;
    hit = 1'b0;
    pc  = CW'(p);
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      f  = range_pair[i >> 1][(i & 1) * 32 +: RANGE_WIDTH];
      l  = range_pair[i >> 1][(i & 1) * 32 + RANGE_WIDTH +: RANGE_WIDTH];
      fc = CW'(f);
      lc = CW'(l);
      if ((4'(i) < range_active) && (pc >= fc) && ((l == '0) || (pc <= lc))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode          <= 1'b0;
      field_delimiter      <= DELIM_RESET;
      suppress_undelimited <= 1'b0;
      range_count          <= '0;
      range_pair           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SELECT_MODE:  select_mode          <= cfg_data[0];
        CFG_FIELD_DELIM:  field_delimiter      <= cfg_data[7:0];
        CFG_SUPPRESS:     suppress_undelimited <= cfg_data[0];
        CFG_RANGE_COUNT:  range_count          <= cfg_data[3:0];
        CFG_RANGE_PAIR_A: range_pair[0]        <= cfg_data;
        CFG_RANGE_PAIR_B: range_pair[1]        <= cfg_data;
        CFG_RANGE_PAIR_C: range_pair[2]        <= cfg_data;
        CFG_RANGE_PAIR_D: range_pair[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = (fill > QCW'(QUEUE_DEPTH - 2));
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (fill != '0);
  assign out_fire  = out_valid && !out_stall;

  assign pos_inc  = (position_count == COUNT_MAX) ? position_count : position_count + 1'b1;
  assign fld_inc  = (field_number == COUNT_MAX) ? field_number : field_number + 1'b1;
  assign sel_pos  = select_mode ? field_number : pos_inc;
  assign sel_a    = is_sel(sel_pos);
  assign sel_b    = is_sel(fld_inc);
  assign is_delim = (in_byte == field_delimiter);

  always_comb begin
    p0 = 1'b0;
    p1 = 1'b0;
    slot0 = '{kind: KIND_NEWLINE, data: 8'h00, last: 1'b0};
    slot1 = '{kind: KIND_NEWLINE, data: 8'h00, last: 1'b0};
    fw_mid = field_written;
    position_count_next = position_count;
    field_number_next   = field_number;
    delimiter_seen_next = delimiter_seen;
    field_written_next  = field_written;
    if (line_end) begin
      if (select_mode && !delimiter_seen) begin
        p0 = 1'b1;
        slot0.kind = suppress_undelimited ? KIND_DROP : KIND_KEEP;
        p1 = !suppress_undelimited;
      end else begin
        p1 = 1'b1;
      end
      position_count_next = '0;
      field_number_next   = {{(PW-1){1'b0}}, 1'b1};
      delimiter_seen_next = 1'b0;
      field_written_next  = 1'b0;
    end else begin
      position_count_next = pos_inc;
      slot1.data = in_byte;
      if (!select_mode) begin
        p1 = sel_a;
        slot1.kind = KIND_FINAL;
      end else if (is_delim) begin
        if (!delimiter_seen) begin
          delimiter_seen_next = 1'b1;
          p0 = 1'b1;
          slot0.kind = sel_a ? KIND_KEEP : KIND_DROP;
          fw_mid = sel_a;
        end
        p1 = sel_b && fw_mid;
        slot1.kind = KIND_FINAL;
        field_written_next = fw_mid || sel_b;
        field_number_next  = fld_inc;
      end else if (!delimiter_seen) begin
        p1 = 1'b1;
        slot1.kind = KIND_HELD;
      end else begin
        p1 = sel_a;
        slot1.kind = KIND_FINAL;
      end
    end
    // compact present slots to the queue's write order
    n_res = {1'b0, p0} + {1'b0, p1};
    r0 = p0 ? slot0 : slot1;
    r1 = slot1;
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      field_number   <= {{(PW-1){1'b0}}, 1'b1};
      delimiter_seen <= 1'b0;
      field_written  <= 1'b0;
    end else if (in_fire) begin
      position_count <= position_count_next;
      field_number   <= field_number_next;
      delimiter_seen <= delimiter_seen_next;
      field_written  <= field_written_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (n_res != 2'd0)) begin
      queue[wr_ptr] <= r0;
      if (n_res == 2'd2) begin
        queue[wr_ptr + 1'b1] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QPW'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (in_fire ? QCW'(n_res) : QCW'(0)) - QCW'(out_fire);
    end
  end

  assign out_kind = queue[rd_ptr].kind;
  assign out_byte = queue[rd_ptr].data;
  assign run_last = queue[rd_ptr].last;

endmodule

### rtl/dfbs_checker.sv
// ----------------------------------------------------------------------------
// dfbs_checker
// Port-level checks of the selector's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dfbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic       run_last
);
  import dfbs_pkg::*;

  // only a keep verdict is ever followed by a second result of the same request
  a_non_last_is_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> out_kind == KIND_KEEP)
    else $error("non-last result is not a keep verdict");

  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("second result of a request not ready");

  a_marker_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_KEEP || out_kind == KIND_DROP ||
                  out_kind == KIND_NEWLINE) |-> out_byte == 8'h00)
    else $error("verdict or newline carries a byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
                               $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind delimited_field_byte_selector dfbs_checker u_dfbs_checker (.*);
